@@ rtl/rfp_pkg.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser package
// Shared types, codes and the header check used by the parser modules.
// ----------------------------------------------------------------------------
package rfp_pkg;

  // Packet kinds
  localparam logic [1:0] KIND_PLI  = 2'd0;
  localparam logic [1:0] KIND_FIR  = 2'd1;
  localparam logic [1:0] KIND_SLI  = 2'd2;
  localparam logic [1:0] KIND_NACK = 2'd3;

  // Status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT_HDR   = 4'd1;
  localparam logic [3:0] ST_VERSION     = 4'd2;
  localparam logic [3:0] ST_PADDING     = 4'd3;
  localparam logic [3:0] ST_TYPE        = 4'd4;
  localparam logic [3:0] ST_FORMAT      = 4'd5;
  localparam logic [3:0] ST_SHORT_LEN   = 4'd6;
  localparam logic [3:0] ST_TRUNCATED   = 4'd7;
  localparam logic [3:0] ST_FCI_SMALL   = 4'd8;
  localparam logic [3:0] ST_MISALIGNED  = 4'd9;
  localparam logic [3:0] ST_PLI_LEN     = 4'd10;

  // Configuration register indexes and reset values
  localparam logic       CFG_IDX_PSFB  = 1'b0;
  localparam logic       CFG_IDX_RTPFB = 1'b1;
  localparam logic [7:0] PSFB_RESET    = 8'd206;
  localparam logic [7:0] RTPFB_RESET   = 8'd205;

  // Header field values
  localparam logic [1:0] RTCP_VERSION = 2'd2;
  localparam logic [4:0] FMT_PLI      = 5'd1;
  localparam logic [4:0] FMT_FIR      = 5'd4;
  localparam logic [4:0] FMT_SLI      = 5'd2;
  localparam logic [4:0] FMT_NACK     = 5'd1;

  // Byte position counter
  localparam int unsigned POS_W   = 19;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] psfb_type;
    logic [7:0] rtpfb_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] expected_kind;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        is_status;
    logic [1:0]  packet_kind;
    logic [31:0] sender_id;
    logic [31:0] media_id;
    logic [31:0] entry_word_a;
    logic [15:0] entry_word_b;
    logic [31:0] picture_word;
    logic [3:0]  status_code;
    logic        last;
  } out_item_t;

  // Results of one byte, in order; count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // Header check without truncation
  function automatic logic [3:0] header_code(input logic [1:0]  kind,
                                             input logic [7:0]  first_byte,
                                             input logic [7:0]  pt_byte,
                                             input logic [15:0] len_words,
                                             input cfg_t        cfg);
    logic [7:0] exp_pt;
    logic [4:0] exp_fmt;
    logic       wide_entry;
    logic [3:0] code;
    exp_pt     = (kind == KIND_NACK) ? cfg.rtpfb_type : cfg.psfb_type;
    wide_entry = (kind == KIND_FIR) || (kind == KIND_SLI);
    unique case (kind)
      KIND_PLI: exp_fmt = FMT_PLI;
      KIND_FIR: exp_fmt = FMT_FIR;
      KIND_SLI: exp_fmt = FMT_SLI;
      default:  exp_fmt = FMT_NACK;
    endcase
    // FCI bytes are (len_words - 2) * 4
    if (first_byte[7:6] != RTCP_VERSION)                  code = ST_VERSION;
    else if (first_byte[5])                               code = ST_PADDING;
    else if (pt_byte != exp_pt)                           code = ST_TYPE;
    else if (first_byte[4:0] != exp_fmt)                  code = ST_FORMAT;
    else if (len_words < 16'd2)                           code = ST_SHORT_LEN;
    else if ((wide_entry && len_words < 16'd4) ||
             (kind == KIND_NACK && len_words < 16'd3))    code = ST_FCI_SMALL;
    else if (wide_entry && len_words[0])                  code = ST_MISALIGNED;
    else if (kind == KIND_PLI && len_words != 16'd2)      code = ST_PLI_LEN;
    else                                                  code = ST_OK;
    return code;
  endfunction

endpackage

@@ rtl/rfp_in_if.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser input channel
// Valid/ready channel carrying one buffer byte per request.
// ----------------------------------------------------------------------------
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] expected_kind;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output expected_kind,
                  output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input expected_kind,
                  input end_of_buffer, output ready);
endinterface

@@ rtl/rfp_out_if.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser result channel
// Valid/ready channel carrying decoded entries and buffer status.
// ----------------------------------------------------------------------------
interface rfp_out_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [1:0]  packet_kind;
  logic [31:0] sender_id;
  logic [31:0] media_id;
  logic [31:0] entry_word_a;
  logic [15:0] entry_word_b;
  logic [31:0] picture_word;
  logic [3:0]  status_code;
  logic        last;

  modport source (output valid, output is_status, output packet_kind,
                  output sender_id, output media_id, output entry_word_a,
                  output entry_word_b, output picture_word, output status_code,
                  output last, input ready);
  modport sink   (input valid, input is_status, input packet_kind,
                  input sender_id, input media_id, input entry_word_a,
                  input entry_word_b, input picture_word, input status_code,
                  input last, output ready);
endinterface

@@ rtl/rfp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser configuration registers
// Expected payload types for PSFB and RTPFB packets.
// ----------------------------------------------------------------------------
module rfp_cfg_regs
  import rfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.psfb_type  <= PSFB_RESET;
      cfg_q.rtpfb_type <= RTPFB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_PSFB:  cfg_q.psfb_type  <= cfg_wdata_i;
        CFG_IDX_RTPFB: cfg_q.rtpfb_type <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/rfp_parser.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser byte stage
// Holds the header and entry state and forms the results of each byte.
// ----------------------------------------------------------------------------
module rfp_parser
  import rfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output push_t    push_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       pt_q, pt_d;
  logic [15:0]      len_q, len_d;
  logic [31:0]      sender_q, sender_d;
  logic [31:0]      media_q, media_d;
  logic [63:0]      shift_q, shift_d;

  logic [7:0]       b;
  logic             eob;
  logic [16:0]      words_cur, words_nxt;
  logic [POS_W-1:0] total_cur, total_nxt;
  logic [POS_W:0]   size;
  logic [3:0]       hdr_cur, hdr_nxt, code;
  logic             in_fci, emit_entry, trunc;
  logic [63:0]      shift_new;
  out_item_t        entry_item, status_item;

  assign b   = item_i.data_byte;
  assign eob = item_i.end_of_buffer;

  // Declared packet size in bytes, before and after this byte
  assign words_cur = {1'b0, len_q} + 17'd1;
  assign words_nxt = {1'b0, len_d} + 17'd1;
  assign total_cur = {words_cur, 2'b00};
  assign total_nxt = {words_nxt, 2'b00};
  assign size      = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};

  assign hdr_cur = header_code(kind_q, first_q, pt_q, len_q, cfg_i);
  assign hdr_nxt = header_code(kind_d, first_d, pt_d, len_d, cfg_i);

  // Header capture
  always_comb begin
    kind_d   = kind_q;
    first_d  = first_q;
    pt_d     = pt_q;
    len_d    = len_q;
    sender_d = sender_q;
    media_d  = media_q;
    if (pos_q == '0) begin
      kind_d  = item_i.expected_kind;
      first_d = b;
    end else if (pos_q == POS_W'(1)) begin
      pt_d = b;
    end else if (pos_q == POS_W'(2)) begin
      len_d = {b, 8'h00};
    end else if (pos_q == POS_W'(3)) begin
      len_d = {len_q[15:8], b};
    end else if (pos_q < POS_W'(8)) begin
      sender_d = {sender_q[23:0], b};
    end else if (pos_q < POS_W'(12)) begin
      media_d = {media_q[23:0], b};
    end
  end

  // FCI bytes: entries end every 4 (NACK) or 8 (FIR, SLI) bytes from byte 12
  assign in_fci     = (pos_q >= POS_W'(12)) && (pos_q < total_cur) && (hdr_cur == ST_OK);
  assign shift_new  = {shift_q[55:0], b};
  assign emit_entry = in_fci && (kind_q != KIND_PLI) &&
                      ((kind_q == KIND_NACK) ? (pos_q[1:0] == 2'b11)
                                             : (pos_q[2:0] == 3'b011));

  always_comb begin
    shift_d = shift_q;
    if (eob || pos_q == '0) begin
      shift_d = '0;
    end else if (in_fci) begin
      shift_d = shift_new;
    end
  end

  // Entry result
  always_comb begin
    entry_item              = '0;
    entry_item.packet_kind  = kind_q;
    entry_item.sender_id    = sender_q;
    entry_item.media_id     = (kind_q == KIND_FIR) ? 32'd0 : media_q;
    unique case (kind_q)
      KIND_FIR: begin
        entry_item.entry_word_a = shift_new[63:32];
        entry_item.entry_word_b = {8'h00, shift_new[23:16]};
      end
      KIND_SLI: begin
        entry_item.entry_word_a = {16'h0000, shift_new[63:48]};
        entry_item.entry_word_b = shift_new[47:32];
        entry_item.picture_word = shift_new[31:0];
      end
      default: begin
        entry_item.entry_word_a = {16'h0000, shift_new[31:16]};
        entry_item.entry_word_b = shift_new[15:0];
      end
    endcase
  end

  // Status: short buffer, then header faults, then truncation, then FCI faults
  assign trunc = size < {1'b0, total_nxt};

  always_comb begin
    if (pos_q < POS_W'(3)) begin
      code = ST_SHORT_HDR;
    end else if (hdr_nxt >= ST_VERSION && hdr_nxt <= ST_SHORT_LEN) begin
      code = hdr_nxt;
    end else if (trunc) begin
      code = ST_TRUNCATED;
    end else begin
      code = hdr_nxt;
    end
  end

  always_comb begin
    status_item             = '0;
    status_item.is_status   = 1'b1;
    status_item.last        = 1'b1;
    status_item.packet_kind = kind_d;
    status_item.status_code = code;
    if (code == ST_OK) begin
      status_item.sender_id = sender_d;
      status_item.media_id  = (kind_d == KIND_FIR) ? 32'd0 : media_d;
    end
  end

  // Results to the queue, in order
  always_comb begin
    push_o        = '0;
    push_o.second = status_item;
    push_o.first  = emit_entry ? entry_item : status_item;
    if (accept_i) begin
      push_o.count = {1'b0, emit_entry} + {1'b0, eob};
    end
  end

  assign pos_d = eob ? '0 : ((pos_q != POS_MAX) ? pos_q + POS_W'(1) : POS_MAX);

  // State update on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      kind_q   <= '0;
      first_q  <= '0;
      pt_q     <= '0;
      len_q    <= '0;
      sender_q <= '0;
      media_q  <= '0;
      shift_q  <= '0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      kind_q   <= kind_d;
      first_q  <= first_d;
      pt_q     <= pt_d;
      len_q    <= len_d;
      sender_q <= sender_d;
      media_q  <= media_d;
      shift_q  <= shift_d;
    end
  end

endmodule

@@ rtl/rfp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser result queue
// Four-entry queue taking up to two results a cycle and giving one.
// ----------------------------------------------------------------------------
module rfp_out_fifo
  import rfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  logic      pop_i,
  output logic      space_o,
  output logic      valid_o,
  output out_item_t head_o
);

  out_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              pop;

  assign pop     = pop_i && (count_q != '0);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  // room for the two results a byte may bring
  assign space_o = count_q <= QCNT_W'(QDEPTH - 2);

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + QPTR_W'(1)] <= push_i.second;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_i.count);
      rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
      count_q  <= count_q + QCNT_W'(push_i.count) - QCNT_W'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("result queue over-filled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (count_q <= QCNT_W'(QDEPTH - 2)))
    else $error("results pushed without room");

  a_pair_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd2 && !pop) |=> (count_q == $past(count_q) + QCNT_W'(2)))
    else $error("entry and status pair not both queued");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd2) |-> (!push_i.first.is_status && push_i.second.is_status))
    else $error("status queued ahead of its entry");
`endif

endmodule

@@ rtl/rtcp_feedback_parser.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser
// Parses PLI, FIR, SLI and generic NACK feedback packets a byte at a time.
// ----------------------------------------------------------------------------
// One buffer byte is taken per cycle, with no stall of its own: each byte
// updates the header and entry registers in the cycle it is accepted, and its
// results (a decoded entry, the buffer status, or both on the final byte)
// enter a four-entry result queue, from which they are offered in order. The
// input stalls only while the queue holds more than two results, so a
// consumer that takes one result per cycle sees a sustained rate of one byte
// per cycle. Entries appear as their last byte arrives once the header is
// valid; the status result, flagged last, closes every buffer, and entries of
// a buffer whose status is not ok should be discarded.
module rtcp_feedback_parser
  import rfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  rfp_in_if.sink     in_ch,
  rfp_out_if.source  out_ch
);

  cfg_t      cfg;
  in_item_t  item;
  push_t     push;
  out_item_t head;
  logic      accept;
  logic      space;

  assign accept             = in_ch.valid && in_ch.ready;
  assign item.data_byte     = in_ch.data_byte;
  assign item.expected_kind = in_ch.expected_kind;
  assign item.end_of_buffer = in_ch.end_of_buffer;
  assign in_ch.ready        = space;

  rfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rfp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .push_o   (push)
  );

  rfp_out_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ch.ready),
    .space_o (space),
    .valid_o (out_ch.valid),
    .head_o  (head)
  );

  // Result fields
  assign out_ch.is_status    = head.is_status;
  assign out_ch.packet_kind  = head.packet_kind;
  assign out_ch.sender_id    = head.sender_id;
  assign out_ch.media_id     = head.media_id;
  assign out_ch.entry_word_a = head.entry_word_a;
  assign out_ch.entry_word_b = head.entry_word_b;
  assign out_ch.picture_word = head.picture_word;
  assign out_ch.status_code  = head.status_code;
  assign out_ch.last         = head.last;

endmodule

@@ tb/rfp_checker.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser checker
// Watches the byte and result channels and the register port, works out the
// entries and status each accepted byte should give, and compares every
// accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfp_checker
  import rfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  rfp_in_if           in_ch,
  rfp_out_if          out_ch,
  output int unsigned error_count_o,
  output int unsigned outstanding_o
);

  // Shadow of the parser registers
  cfg_t             cfg_q;
  logic [POS_W-1:0] pos_q;
  logic [1:0]       kind_q;
  logic [7:0]       first_q;
  logic [7:0]       pt_q;
  logic [15:0]      len_q;
  logic [31:0]      sender_q;
  logic [31:0]      media_q;
  logic [63:0]      fci_shift_q;

  // Results owed by the parser, oldest first
  out_item_t parsed_results[$];

  function automatic int unsigned entry_bytes(input logic [1:0] kind);
    case (kind)
      KIND_PLI:  return 0;
      KIND_NACK: return 4;
      default:   return 8;
    endcase
  endfunction

  function automatic int unsigned declared_bytes();
    return (int'(len_q) + 1) * 4;
  endfunction

  // Header verdict, truncation aside; first failing check wins
  function automatic logic [3:0] header_status();
    logic [7:0]  want_pt;
    logic [4:0]  want_fmt;
    int unsigned total;
    int unsigned fci;
    int unsigned es;
    want_pt = (kind_q == KIND_NACK) ? cfg_q.rtpfb_type : cfg_q.psfb_type;
    case (kind_q)
      KIND_FIR:  want_fmt = FMT_FIR;
      KIND_SLI:  want_fmt = FMT_SLI;
      KIND_NACK: want_fmt = FMT_NACK;
      default:   want_fmt = FMT_PLI;
    endcase
    total = declared_bytes();
    es    = entry_bytes(kind_q);
    if (first_q[7:6] != RTCP_VERSION) return ST_VERSION;
    if (first_q[5]) return ST_PADDING;
    if (pt_q != want_pt) return ST_TYPE;
    if (first_q[4:0] != want_fmt) return ST_FORMAT;
    if (total < 12) return ST_SHORT_LEN;
    fci = total - 12;
    if (fci < es) return ST_FCI_SMALL;
    if (es != 0 && (fci % es) != 0) return ST_MISALIGNED;
    if (kind_q == KIND_PLI && len_q != 16'd2) return ST_PLI_LEN;
    return ST_OK;
  endfunction

  // Append a result to the owed list
  task automatic owe_result(input out_item_t res);
    parsed_results.insert(parsed_results.size(), res);
  endtask

  // One accepted byte: update the shadow and queue what it produces
  task automatic parse_byte(input logic [7:0] data, input logic [1:0] kind,
                            input logic eob);
    int unsigned p;
    int unsigned es;
    logic [3:0]  code;
    out_item_t   res;
    p = 32'(pos_q);
    if (p == 0) begin
      kind_q      = kind;
      first_q     = data;
      fci_shift_q = '0;
    end else if (p == 1) begin
      pt_q = data;
    end else if (p == 2) begin
      len_q = {data, 8'h00};
    end else if (p == 3) begin
      len_q[7:0] = data;
    end else if (p < 8) begin
      sender_q = {sender_q[23:0], data};
    end else if (p < 12) begin
      media_q = {media_q[23:0], data};
    end else if (p < declared_bytes() && header_status() == ST_OK) begin
      es          = entry_bytes(kind_q);
      fci_shift_q = {fci_shift_q[55:0], data};
      if (es != 0 && ((p - 12) % es) == es - 1) begin
        res             = '0;
        res.packet_kind = kind_q;
        res.sender_id   = sender_q;
        res.media_id    = (kind_q == KIND_FIR) ? 32'd0 : media_q;
        case (kind_q)
          KIND_FIR: begin
            // sequence number comes from the sixth entry byte
            res.entry_word_a = fci_shift_q[63:32];
            res.entry_word_b = {8'h00, fci_shift_q[23:16]};
          end
          KIND_SLI: begin
            res.entry_word_a = {16'h0000, fci_shift_q[63:48]};
            res.entry_word_b = fci_shift_q[47:32];
            res.picture_word = fci_shift_q[31:0];
          end
          default: begin
            res.entry_word_a = {16'h0000, fci_shift_q[31:16]};
            res.entry_word_b = fci_shift_q[15:0];
          end
        endcase
        owe_result(res);
      end
    end

    // Status closes the buffer
    if (eob) begin
      if (p + 1 < 4) begin
        code = ST_SHORT_HDR;
      end else begin
        code = header_status();
        if (!(code >= ST_VERSION && code <= ST_SHORT_LEN) && p + 1 < declared_bytes())
          code = ST_TRUNCATED;
      end
      res             = '0;
      res.is_status   = 1'b1;
      res.packet_kind = kind_q;
      res.status_code = code;
      res.last        = 1'b1;
      if (code == ST_OK) begin
        res.sender_id = sender_q;
        res.media_id  = (kind_q == KIND_FIR) ? 32'd0 : media_q;
      end
      owe_result(res);
      pos_q       = '0;
      fci_shift_q = '0;
    end else if (pos_q != POS_MAX) begin
      pos_q = pos_q + POS_W'(1);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count_o++;
    end
  endtask

  // Sample at the edge: register writes, byte requests, then results
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cfg_q.psfb_type  = PSFB_RESET;
      cfg_q.rtpfb_type = RTPFB_RESET;
      pos_q            = '0;
      kind_q           = '0;
      first_q          = '0;
      pt_q             = '0;
      len_q            = '0;
      sender_q         = '0;
      media_q          = '0;
      fci_shift_q      = '0;
      parsed_results.delete();
      error_count_o    = 0;
      outstanding_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_PSFB) cfg_q.psfb_type = cfg_wdata_i;
        else                           cfg_q.rtpfb_type = cfg_wdata_i;
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        parse_byte(in_ch.data_byte, in_ch.expected_kind, in_ch.end_of_buffer);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (parsed_results.size() == 0) begin
          $error("result with nothing owed: is_status %0h, status_code %0h",
                 out_ch.is_status, out_ch.status_code);
          error_count_o++;
        end else begin
          want = parsed_results.pop_front();
          check_field("is_status", want.is_status, out_ch.is_status);
          check_field("packet_kind", want.packet_kind, out_ch.packet_kind);
          check_field("sender_id", want.sender_id, out_ch.sender_id);
          check_field("media_id", want.media_id, out_ch.media_id);
          check_field("entry_word_a", want.entry_word_a, out_ch.entry_word_a);
          check_field("entry_word_b", want.entry_word_b, out_ch.entry_word_b);
          check_field("picture_word", want.picture_word, out_ch.picture_word);
          check_field("status_code", want.status_code, out_ch.status_code);
          check_field("last", want.last, out_ch.last);
        end
      end
      outstanding_o = parsed_results.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// RTCP feedback parser testbench
// Feeds directed and random feedback buffers (well-formed, corrupted, cut
// short and overlong) under several register settings with random stalls on
// both channels; a checker beside the parser predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rfp_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  int unsigned error_count;
  int unsigned outstanding;
  int unsigned bytes_sent;
  logic        steady;
  logic [7:0]  psfb_now;
  logic [7:0]  rtpfb_now;
  logic [7:0]  frame[$];

  rfp_in_if  in_ch ();
  rfp_out_if out_ch ();

  rtcp_feedback_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  rfp_checker parse_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result back-pressure
  always @(posedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 29);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // One byte request; returns just after the edge that took it
  task automatic send_byte(input logic [7:0] data, input logic [1:0] kind,
                           input logic eob);
    while (!steady && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= data;
    in_ch.expected_kind <= kind;
    in_ch.end_of_buffer <= eob;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  // Expected kind only matters on the first byte
  task automatic send_frame(input logic [1:0] kind);
    for (int i = 0; i < frame.size(); i++)
      send_byte(frame[i], (i == 0) ? kind : 2'($urandom_range(3)),
                i == frame.size() - 1);
  endtask

  // Append one byte to the frame
  task automatic add_byte(input logic [7:0] value);
    frame.insert(frame.size(), value);
  endtask

  // Well-formed packet with the given number of FCI entries
  task automatic build_frame(input logic [1:0] kind, input int unsigned entries);
    int unsigned es;
    logic [15:0] words;
    logic [4:0]  fmt;
    es = (kind == KIND_PLI) ? 0 : ((kind == KIND_NACK) ? 4 : 8);
    case (kind)
      KIND_FIR:  fmt = FMT_FIR;
      KIND_SLI:  fmt = FMT_SLI;
      KIND_NACK: fmt = FMT_NACK;
      default:   fmt = FMT_PLI;
    endcase
    words = 16'((12 + entries * es) / 4 - 1);
    frame.delete();
    add_byte({RTCP_VERSION, 1'b0, fmt});
    add_byte((kind == KIND_NACK) ? rtpfb_now : psfb_now);
    add_byte(words[15:8]);
    add_byte(words[7:0]);
    repeat (8 + entries * es) add_byte(8'($urandom));
  endtask

  task automatic set_len(input logic [15:0] words);
    frame[2] = words[15:8];
    frame[3] = words[7:0];
  endtask

  task automatic cut_frame(input int unsigned keep);
    while (frame.size() > keep) void'(frame.pop_back());
  endtask

  task automatic fill_body(input logic [7:0] value);
    for (int i = 4; i < frame.size(); i++) frame[i] = value;
  endtask

  task automatic pad_frame(input int unsigned count);
    repeat (count) add_byte(8'($urandom));
  endtask

  // Hold requests until every owed result is back, then let the queue settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_IDX_PSFB) psfb_now = value;
    else                     rtpfb_now = value;
  endtask

  // Stimulus
  initial begin
    logic [1:0]  kind;
    logic [1:0]  send_kind;
    int unsigned choice;
    int unsigned goal;
    int unsigned rnd_buffers;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.expected_kind = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_IDX_PSFB;
    cfg_wdata_i         = '0;
    bytes_sent          = 0;
    rnd_buffers         = 0;
    steady              = 1'b0;
    psfb_now            = PSFB_RESET;
    rtpfb_now           = RTPFB_RESET;
    rst_ni              = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every kind well-formed, each header fault, cut and overlong
    build_frame(KIND_PLI, 0);
    send_frame(KIND_PLI);
    build_frame(KIND_FIR, 1);
    fill_body(8'hFF);
    send_frame(KIND_FIR);
    build_frame(KIND_SLI, 2);
    fill_body(8'h00);
    send_frame(KIND_SLI);
    build_frame(KIND_NACK, 3);
    send_frame(KIND_NACK);
    build_frame(KIND_FIR, 1);
    cut_frame(1);
    send_frame(KIND_FIR);
    build_frame(KIND_NACK, 1);
    cut_frame(3);
    send_frame(KIND_NACK);
    build_frame(KIND_SLI, 1);
    frame[0] = {2'd0, frame[0][5:0]};
    send_frame(KIND_SLI);
    build_frame(KIND_PLI, 0);
    frame[0] = {2'd3, frame[0][5:0]};
    send_frame(KIND_PLI);
    build_frame(KIND_NACK, 1);
    frame[0][5] = 1'b1;
    send_frame(KIND_NACK);
    build_frame(KIND_FIR, 1);
    frame[1] = ~frame[1];
    send_frame(KIND_FIR);
    build_frame(KIND_FIR, 1);
    frame[0] = {frame[0][7:5], FMT_SLI};
    send_frame(KIND_FIR);
    build_frame(KIND_PLI, 0);
    set_len(16'd1);
    cut_frame(8);
    send_frame(KIND_PLI);
    build_frame(KIND_NACK, 0);
    set_len(16'd0);
    cut_frame(4);
    send_frame(KIND_NACK);
    // cut short after the first entry is out
    build_frame(KIND_FIR, 2);
    cut_frame(frame.size() - 3);
    send_frame(KIND_FIR);
    build_frame(KIND_SLI, 1);
    set_len(16'hFFFF);
    send_frame(KIND_SLI);
    build_frame(KIND_FIR, 0);
    send_frame(KIND_FIR);
    build_frame(KIND_NACK, 0);
    send_frame(KIND_NACK);
    build_frame(KIND_SLI, 1);
    set_len(16'd5);
    pad_frame(4);
    send_frame(KIND_SLI);
    build_frame(KIND_PLI, 0);
    set_len(16'd3);
    pad_frame(4);
    send_frame(KIND_PLI);
    build_frame(KIND_NACK, 2);
    pad_frame(6);
    send_frame(KIND_NACK);
    build_frame(KIND_NACK, 1);
    send_frame(KIND_PLI);
    build_frame(KIND_PLI, 0);
    cut_frame(4);
    send_frame(KIND_PLI);

    // Random phases, one register setting each; extremes first
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_cfg(CFG_IDX_PSFB, 8'h00);
          write_cfg(CFG_IDX_RTPFB, 8'hFF);
        end
        1: begin
          write_cfg(CFG_IDX_PSFB, 8'hFF);
          write_cfg(CFG_IDX_RTPFB, 8'h00);
        end
        2: begin
          write_cfg(CFG_IDX_PSFB, 8'($urandom));
          write_cfg(CFG_IDX_RTPFB, 8'($urandom));
        end
        default: begin
          write_cfg(CFG_IDX_PSFB, PSFB_RESET);
          write_cfg(CFG_IDX_RTPFB, RTPFB_RESET);
        end
      endcase
      goal = bytes_sent + 320;
      while (bytes_sent < goal) begin
        // a long run with no stalls on either side
        steady    = (rnd_buffers >= 20 && rnd_buffers < 40);
        kind      = 2'($urandom_range(3));
        send_kind = kind;
        build_frame(kind, (kind == KIND_PLI) ? 0 : $urandom_range(1, 3));
        choice = $urandom_range(99);
        if (choice < 62) begin
          // well-formed
        end else if (choice < 68) begin
          pad_frame($urandom_range(1, 9));
        end else if (choice < 72) begin
          frame[0] = {2'($urandom_range(2) ^ 2'd2 ^ 2'd2 ^ 2'($urandom_range(1, 3))),
                      frame[0][5:0]};
        end else if (choice < 75) begin
          frame[0][5] = 1'b1;
        end else if (choice < 78) begin
          frame[1] = 8'($urandom);
        end else if (choice < 81) begin
          frame[0] = {frame[0][7:5], 5'($urandom)};
        end else if (choice < 86) begin
          if ($urandom_range(1)) set_len(16'($urandom_range(7)));
          else                   set_len(16'($urandom));
        end else if (choice < 92) begin
          cut_frame($urandom_range(1, frame.size() - 1));
        end else if (choice < 95) begin
          send_kind = kind ^ 2'($urandom_range(1, 3));
        end else begin
          frame.delete();
          pad_frame($urandom_range(1, 20));
        end
        send_frame(send_kind);
        rnd_buffers++;
        if ($urandom_range(19) == 0) wait_drained();
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rfp_pkg.sv
rtl/rfp_in_if.sv
rtl/rfp_out_if.sv
rtl/rfp_cfg_regs.sv
rtl/rfp_parser.sv
rtl/rfp_out_fifo.sv
rtl/rtcp_feedback_parser.sv
tb/rfp_checker.sv
tb/testbench.sv
